// ===== design/atb_pkg.sv =====
`timescale 1ns / 1ps

package atb_pkg;

    // most fired reports one tick may give
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 4;

    typedef enum logic [2:0] {
        REQ_SETUP   = 3'd0,
        REQ_START   = 3'd1,
        REQ_STOP    = 3'd2,
        REQ_RESTART = 3'd3,
        REQ_SETPER  = 3'd4,
        REQ_TICK    = 3'd5
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_RESP,
        ST_FLUSH
    } state_t;

    // store port control from the sequencer
    typedef struct packed {
        logic rd_en;
        logic per_we;
        logic due_we;
    } store_ctl_t;

    // one result word
    typedef struct packed {
        logic       status_ok;
        logic       fired;
        logic [2:0] fired_channel;
        logic       last_result;
    } res_t;

endpackage

// ===== design/atb_store.sv =====
`timescale 1ns / 1ps

module atb_store #(
    parameter int CHANNELS  = 8,
    parameter int IDX_W     = 3,
    parameter int TIME_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  atb_pkg::store_ctl_t  ctl,
    input  logic [IDX_W-1:0]     rd_addr,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [31:0]          per_wdata,
    input  logic [TIME_BITS-1:0] due_wdata,
    output logic [31:0]          period_q,
    output logic [TIME_BITS-1:0] due_q
);

    logic [31:0]          per_mem [CHANNELS];
    logic [TIME_BITS-1:0] due_mem [CHANNELS];

    // written-since-reset bits, an unwritten entry reads as zero
    logic [CHANNELS-1:0]  per_vld_reg;
    logic [CHANNELS-1:0]  due_vld_reg;

    logic [31:0]          per_raw_reg;
    logic [TIME_BITS-1:0] due_raw_reg;
    logic                 per_hit_reg;
    logic                 due_hit_reg;

    always_ff @(posedge aclk) begin
        if (ctl.per_we) begin
            per_mem[wr_addr] <= per_wdata;
        end
        if (ctl.due_we) begin
            due_mem[wr_addr] <= due_wdata;
        end
        if (ctl.rd_en) begin
            per_raw_reg <= per_mem[rd_addr];
            due_raw_reg <= due_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            per_vld_reg <= '0;
            due_vld_reg <= '0;
            per_hit_reg <= 1'b0;
            due_hit_reg <= 1'b0;
        end else begin
            if (ctl.per_we) begin
                per_vld_reg[wr_addr] <= 1'b1;
            end
            if (ctl.due_we) begin
                due_vld_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en) begin
                per_hit_reg <= per_vld_reg[rd_addr];
                due_hit_reg <= due_vld_reg[rd_addr];
            end
        end
    end

    assign period_q = per_hit_reg ? per_raw_reg : '0;
    assign due_q    = due_hit_reg ? due_raw_reg : '0;

endmodule

// ===== design/atb_alu.sv =====
`timescale 1ns / 1ps

module atb_alu #(
    parameter int TIME_BITS = 32
) (
    input  logic [31:0]          now_time,
    input  logic [31:0]          period,
    input  logic [TIME_BITS-1:0] due,
    output logic [TIME_BITS-1:0] next_due,
    output logic                 reached
);

    logic [TIME_BITS+31:0] now_ext;
    logic [TIME_BITS+31:0] per_ext;
    logic [TIME_BITS-1:0]  now_t;
    logic [TIME_BITS-1:0]  diff;

    // fit the 32-bit fields to the time width
    assign now_ext  = {{TIME_BITS{1'b0}}, now_time};
    assign per_ext  = {{TIME_BITS{1'b0}}, period};
    assign now_t    = now_ext[TIME_BITS-1:0];

    assign next_due = now_t + per_ext[TIME_BITS-1:0];

    // wrap-safe: reached when now minus due is not negative
    assign diff     = now_t - due;
    assign reached  = ~diff[TIME_BITS-1];

endmodule

// ===== design/atb_seq.sv =====
`timescale 1ns / 1ps

module atb_seq #(
    parameter int CHANNELS  = 8,
    parameter int IDX_W     = 3,
    parameter int TIME_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [2:0]           req_type,
    input  logic [2:0]           channel,
    input  logic [31:0]          period_value,
    input  logic                 periodic_mode,
    input  logic                 has_handler,
    input  logic [31:0]          now_time,
    input  logic                 out_free,
    input  logic [31:0]          period_q,
    input  logic [TIME_BITS-1:0] due_q,
    output logic                 idle,
    output logic                 push,
    output atb_pkg::res_t        res,
    output atb_pkg::store_ctl_t  ctl,
    output logic [IDX_W-1:0]     addr,
    output logic [31:0]          per_wdata,
    output logic [TIME_BITS-1:0] due_wdata
);

    atb_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [atb_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                     pend_vld_reg, pend_vld_next;
    logic [2:0]               pend_ch_reg, pend_ch_next;
    logic                     ok_reg, ok_next;
    logic [CHANNELS-1:0]      armed_reg, armed_next;
    logic [CHANNELS-1:0]      periodic_reg, periodic_next;
    logic [CHANNELS-1:0]      handler_reg, handler_next;

    logic                     is_tick;
    logic                     cmd_valid;
    logic [IDX_W+2:0]         ch_ext;
    logic [IDX_W-1:0]         ch_idx;
    logic [IDX_W+2:0]         idx_ext;
    logic [2:0]               idx_low;
    logic                     idx_last;
    logic                     cnt_last;
    logic [31:0]              add_period;
    logic [TIME_BITS-1:0]     sum;
    logic                     reached;
    logic                     fire;
    logic                     go;

    assign is_tick   = (req_type == atb_pkg::REQ_TICK);
    assign cmd_valid = (req_type <= atb_pkg::REQ_SETPER) && (32'(channel) < CHANNELS);
    assign ch_ext    = {{IDX_W{1'b0}}, channel};
    assign ch_idx    = ch_ext[IDX_W-1:0];
    assign idx_ext   = {3'b000, idx_reg};
    assign idx_low   = idx_ext[2:0];
    assign idx_last  = (idx_reg == IDX_W'(CHANNELS - 1));
    assign cnt_last  = (cnt_reg == atb_pkg::CNT_W'(atb_pkg::MAX_RESULTS - 1));
    assign addr      = is_tick ? idx_reg : ch_idx;

    assign add_period = (req_type == atb_pkg::REQ_SETPER) ? period_value : period_q;

    atb_alu #(
        .TIME_BITS (TIME_BITS)
    ) u_alu (
        .now_time (now_time),
        .period   (add_period),
        .due      (due_q),
        .next_due (sum),
        .reached  (reached)
    );

    assign fire = armed_reg[idx_reg] && handler_reg[idx_reg] && (period_q != '0) && reached;
    // a second fired channel must first move the held one out
    assign go   = !fire || !pend_vld_reg || out_free;
    assign idle = (state_reg == atb_pkg::ST_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            atb_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = atb_pkg::ST_READ;
                end
            end
            atb_pkg::ST_READ: begin
                state_next = atb_pkg::ST_EVAL;
            end
            atb_pkg::ST_EVAL: begin
                if (!is_tick) begin
                    state_next = atb_pkg::ST_RESP;
                end else if (go) begin
                    if (idx_last || (fire && cnt_last)) begin
                        state_next = atb_pkg::ST_FLUSH;
                    end else begin
                        state_next = atb_pkg::ST_READ;
                    end
                end
            end
            atb_pkg::ST_RESP, atb_pkg::ST_FLUSH: begin
                if (out_free) begin
                    state_next = atb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = atb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        pend_vld_next = pend_vld_reg;
        pend_ch_next  = pend_ch_reg;
        ok_next       = ok_reg;
        armed_next    = armed_reg;
        periodic_next = periodic_reg;
        handler_next  = handler_reg;
        ctl           = '0;
        push          = 1'b0;
        res           = '0;
        per_wdata     = period_value;
        due_wdata     = sum;

        unique case (state_reg)
            atb_pkg::ST_IDLE: begin
                if (start) begin
                    idx_next      = '0;
                    cnt_next      = '0;
                    pend_vld_next = 1'b0;
                end
            end
            atb_pkg::ST_READ: begin
                ctl.rd_en = 1'b1;
            end
            atb_pkg::ST_EVAL: begin
                if (is_tick) begin
                    if (go) begin
                        if (fire) begin
                            if (periodic_reg[idx_reg]) begin
                                ctl.due_we = 1'b1;
                            end else begin
                                armed_next[idx_reg] = 1'b0;
                            end
                            if (pend_vld_reg) begin
                                push              = 1'b1;
                                res.status_ok     = 1'b1;
                                res.fired         = 1'b1;
                                res.fired_channel = pend_ch_reg;
                            end
                            pend_vld_next = 1'b1;
                            pend_ch_next  = idx_low;
                            cnt_next      = cnt_reg + 1'b1;
                        end
                        if (!idx_last) begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                end else if (!cmd_valid) begin
                    ok_next = 1'b0;
                end else begin
                    unique case (atb_pkg::req_t'(req_type))
                        atb_pkg::REQ_SETUP: begin
                            ctl.per_we          = 1'b1;
                            ctl.due_we          = 1'b1;
                            due_wdata           = '0;
                            handler_next[ch_idx]  = has_handler;
                            periodic_next[ch_idx] = periodic_mode;
                            armed_next[ch_idx]    = 1'b0;
                            ok_next             = 1'b1;
                        end
                        atb_pkg::REQ_START, atb_pkg::REQ_RESTART: begin
                            if (handler_reg[ch_idx] && (period_q != '0)) begin
                                armed_next[ch_idx] = 1'b1;
                                ctl.due_we         = 1'b1;
                                ok_next            = 1'b1;
                            end else begin
                                ok_next = 1'b0;
                            end
                        end
                        atb_pkg::REQ_STOP: begin
                            armed_next[ch_idx] = 1'b0;
                            ok_next            = 1'b1;
                        end
                        atb_pkg::REQ_SETPER: begin
                            if (period_value != '0) begin
                                ctl.per_we = 1'b1;
                                ctl.due_we = armed_reg[ch_idx];
                                ok_next    = 1'b1;
                            end else begin
                                ok_next = 1'b0;
                            end
                        end
                        default: begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            atb_pkg::ST_RESP: begin
                if (out_free) begin
                    push            = 1'b1;
                    res.status_ok   = ok_reg;
                    res.last_result = 1'b1;
                end
            end
            atb_pkg::ST_FLUSH: begin
                if (out_free) begin
                    push              = 1'b1;
                    res.status_ok     = 1'b1;
                    res.fired         = pend_vld_reg;
                    res.fired_channel = pend_vld_reg ? pend_ch_reg : 3'd0;
                    res.last_result   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= atb_pkg::ST_IDLE;
            idx_reg      <= '0;
            cnt_reg      <= '0;
            pend_vld_reg <= 1'b0;
            pend_ch_reg  <= '0;
            ok_reg       <= 1'b0;
            armed_reg    <= '0;
            periodic_reg <= '1;
            handler_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            cnt_reg      <= cnt_next;
            pend_vld_reg <= pend_vld_next;
            pend_ch_reg  <= pend_ch_next;
            ok_reg       <= ok_next;
            armed_reg    <= armed_next;
            periodic_reg <= periodic_next;
            handler_reg  <= handler_next;
        end
    end

endmodule

// ===== design/multi_channel_alarm_timer_bank.sv =====
`timescale 1ns / 1ps

// channel   direction  ports
// s_        in         s_valid s_ready s_req_type s_channel s_period_value
//                      s_periodic_mode s_has_handler s_now_time
// m_        out        m_valid m_ready m_status_ok m_fired m_fired_channel
//                      m_last_result
//
// a command passes read, compare and response states before loading the output register
// a tick reads then compares each channel in turn on the shared time unit, stops at
// MAX_RESULTS fired, and loads its last word from flush; s_ready stays low until then
// reset (aresetn low, synchronous) clears all flags, sets periodic, zeroes periods and dues
// m_ready low holds the scan only when a second fired channel finds the output register
// and the held report both occupied, and holds the last word until the register frees

module multi_channel_alarm_timer_bank #(
    parameter int CHANNELS  = 8,
    parameter int TIME_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [2:0]  s_channel,
    input  logic [31:0] s_period_value,
    input  logic        s_periodic_mode,
    input  logic        s_has_handler,
    input  logic [31:0] s_now_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status_ok,
    output logic        m_fired,
    output logic [2:0]  m_fired_channel,
    output logic        m_last_result
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // captured input word, held for the whole item
    logic [2:0]  req_reg;
    logic [2:0]  ch_reg;
    logic [31:0] per_reg;
    logic        periodic_reg;
    logic        handler_reg;
    logic [31:0] now_reg;

    // output register
    logic          m_valid_reg;
    atb_pkg::res_t m_res_reg;

    logic                 start;
    logic                 idle;
    logic                 out_free;
    logic                 push;
    atb_pkg::res_t        res;
    atb_pkg::store_ctl_t  ctl;
    logic [IDX_W-1:0]     addr;
    logic [31:0]          per_wdata;
    logic [TIME_BITS-1:0] due_wdata;
    logic [31:0]          period_q;
    logic [TIME_BITS-1:0] due_q;

    assign s_ready  = idle;
    assign start    = s_valid && idle;
    // the output register can take a word when empty or draining this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (start) begin
            req_reg      <= s_req_type;
            ch_reg       <= s_channel;
            per_reg      <= s_period_value;
            periodic_reg <= s_periodic_mode;
            handler_reg  <= s_has_handler;
            now_reg      <= s_now_time;
        end
        if (push) begin
            m_res_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status_ok     = m_res_reg.status_ok;
    assign m_fired         = m_res_reg.fired;
    assign m_fired_channel = m_res_reg.fired_channel;
    assign m_last_result   = m_res_reg.last_result;

    // sequencer: command decode, channel scan, flags and report ordering
    atb_seq #(
        .CHANNELS  (CHANNELS),
        .IDX_W     (IDX_W),
        .TIME_BITS (TIME_BITS)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (start),
        .req_type      (req_reg),
        .channel       (ch_reg),
        .period_value  (per_reg),
        .periodic_mode (periodic_reg),
        .has_handler   (handler_reg),
        .now_time      (now_reg),
        .out_free      (out_free),
        .period_q      (period_q),
        .due_q         (due_q),
        .idle          (idle),
        .push          (push),
        .res           (res),
        .ctl           (ctl),
        .addr          (addr),
        .per_wdata     (per_wdata),
        .due_wdata     (due_wdata)
    );

    // period and due time memories, one read and one write per cycle, both at the one address
    atb_store #(
        .CHANNELS  (CHANNELS),
        .IDX_W     (IDX_W),
        .TIME_BITS (TIME_BITS)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .rd_addr   (addr),
        .wr_addr   (addr),
        .per_wdata (per_wdata),
        .due_wdata (due_wdata),
        .period_q  (period_q),
        .due_q     (due_q)
    );

endmodule

// ===== dv/alarm_check_pkg.sv =====
`timescale 1ns / 1ps

package alarm_check_pkg;

    localparam int NUM_CH = 8;

    // request codes the block does not define
    localparam logic [2:0] REQ_RSVD_6 = 3'd6;
    localparam logic [2:0] REQ_RSVD_7 = 3'd7;

    class alarm_scoreboard;

        logic [31:0]   period_q [NUM_CH];
        logic [31:0]   due_q    [NUM_CH];
        bit            armed_q    [NUM_CH];
        bit            periodic_q [NUM_CH];
        bit            handler_q  [NUM_CH];
        atb_pkg::res_t expected_reports [$];
        int            errors;

        function new();
            for (int i = 0; i < NUM_CH; i++) begin
                period_q[i]   = '0;
                due_q[i]      = '0;
                armed_q[i]    = 1'b0;
                periodic_q[i] = 1'b1;
                handler_q[i]  = 1'b0;
            end
            errors = 0;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void push_report(bit ok, bit fired, logic [2:0] ch, bit last);
            atb_pkg::res_t r;
            r.status_ok     = ok;
            r.fired         = fired;
            r.fired_channel = ch;
            r.last_result   = last;
            expected_reports.push_back(r);
        endfunction

        function bit try_arm(int ch, logic [31:0] now);
            if (!handler_q[ch] || period_q[ch] == 0)
                return 1'b0;
            armed_q[ch] = 1'b1;
            due_q[ch]   = now + period_q[ch];
            return 1'b1;
        endfunction

        // predict the words caused by one accepted request
        function void note_request(logic [2:0] req, logic [2:0] ch, logic [31:0] period,
                                   bit periodic, bit handler, logic [31:0] now);
            logic [31:0] lag;
            int          hits [$];
            int          c;
            bit          ok;
            c  = int'(ch);
            ok = 1'b0;
            if (req == atb_pkg::REQ_TICK) begin
                for (int i = 0; i < NUM_CH && hits.size() < atb_pkg::MAX_RESULTS; i++) begin
                    if (!armed_q[i] || !handler_q[i] || period_q[i] == 0)
                        continue;
                    // wrap-safe: due is reached when now - due is not negative
                    lag = now - due_q[i];
                    if (lag[31])
                        continue;
                    if (periodic_q[i])
                        due_q[i] = now + period_q[i];
                    else
                        armed_q[i] = 1'b0;
                    hits.push_back(i);
                end
                if (hits.size() == 0)
                    push_report(1'b1, 1'b0, 3'd0, 1'b1);
                for (int k = 0; k < hits.size(); k++)
                    push_report(1'b1, 1'b1, 3'(hits[k]), k == hits.size() - 1);
                return;
            end
            case (req)
                atb_pkg::REQ_SETUP: begin
                    period_q[c]   = period;
                    handler_q[c]  = handler;
                    periodic_q[c] = periodic;
                    armed_q[c]    = 1'b0;
                    due_q[c]      = '0;
                    ok            = 1'b1;
                end
                atb_pkg::REQ_START, atb_pkg::REQ_RESTART: ok = try_arm(c, now);
                atb_pkg::REQ_STOP: begin
                    armed_q[c] = 1'b0;
                    ok         = 1'b1;
                end
                atb_pkg::REQ_SETPER: begin
                    if (period != 0) begin
                        period_q[c] = period;
                        if (armed_q[c])
                            due_q[c] = now + period;
                        ok = 1'b1;
                    end
                end
                default: ok = 1'b0;
            endcase
            push_report(ok, 1'b0, 3'd0, 1'b1);
        endfunction

        function void check_report(logic ok, logic fired, logic [2:0] ch, logic last);
            atb_pkg::res_t exp;
            if (expected_reports.size() == 0) begin
                $error("unexpected word: status_ok %0d fired %0d fired_channel %0d last %0d",
                       ok, fired, ch, last);
                errors++;
                return;
            end
            exp = expected_reports.pop_front();
            if (ok !== exp.status_ok) begin
                $error("status_ok: expected %0d, got %0d", exp.status_ok, ok);
                errors++;
            end
            if (fired !== exp.fired) begin
                $error("fired: expected %0d, got %0d", exp.fired, fired);
                errors++;
            end
            if (ch !== exp.fired_channel) begin
                $error("fired_channel: expected %0d, got %0d", exp.fired_channel, ch);
                errors++;
            end
            if (last !== exp.last_result) begin
                $error("last_result: expected %0d, got %0d", exp.last_result, last);
                errors++;
            end
        endfunction

    endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // bound on a tick scan: a read and a compare per channel, plus the output stage
    localparam int SCAN_CYCLES    = 2 * alarm_check_pkg::NUM_CH + 2;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_PASS = 50;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_req_type;
    logic [2:0]  s_channel;
    logic [31:0] s_period_value;
    logic        s_periodic_mode;
    logic        s_has_handler;
    logic [31:0] s_now_time;
    logic        m_valid;
    logic        m_ready;
    logic        m_status_ok;
    logic        m_fired;
    logic [2:0]  m_fired_channel;
    logic        m_last_result;

    alarm_check_pkg::alarm_scoreboard sb;

    // idle rates in percent, per cycle
    int          send_idle_pct;
    int          recv_idle_pct;
    // each bump asks the receiver for one long hold-off
    int          holdoff_asked;
    // running millisecond clock used by well-formed traffic
    logic [31:0] cur_time;
    int          quiet_cycles;

    multi_channel_alarm_timer_bank dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_channel       (s_channel),
        .s_period_value  (s_period_value),
        .s_periodic_mode (s_periodic_mode),
        .s_has_handler   (s_has_handler),
        .s_now_time      (s_now_time),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status_ok     (m_status_ok),
        .m_fired         (m_fired),
        .m_fired_channel (m_fired_channel),
        .m_last_result   (m_last_result)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // offer one word, hold it until taken, then maybe go quiet for a while
    task automatic send_word(logic [2:0] req, logic [2:0] ch, logic [31:0] period,
                             logic periodic, logic handler, logic [31:0] now);
        s_valid         <= 1'b1;
        s_req_type      <= req;
        s_channel       <= ch;
        s_period_value  <= period;
        s_periodic_mode <= periodic;
        s_has_handler   <= handler;
        s_now_time      <= now;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req, ch, period, periodic, handler, now);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // stop offering and let every pending word come out
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    // mostly well-formed traffic on a slowly advancing clock, with some noise
    task automatic rand_request();
        logic [2:0]  req;
        logic [2:0]  ch;
        logic [31:0] period;
        logic [31:0] now;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            req = atb_pkg::REQ_TICK;
        else if (pick < 50)
            req = atb_pkg::REQ_SETUP;
        else if (pick < 63)
            req = atb_pkg::REQ_START;
        else if (pick < 72)
            req = atb_pkg::REQ_RESTART;
        else if (pick < 79)
            req = atb_pkg::REQ_STOP;
        else if (pick < 94)
            req = atb_pkg::REQ_SETPER;
        else
            req = $urandom_range(0, 1) ? alarm_check_pkg::REQ_RSVD_7
                                       : alarm_check_pkg::REQ_RSVD_6;
        ch   = 3'($urandom_range(0, alarm_check_pkg::NUM_CH - 1));
        pick = $urandom_range(0, 99);
        // short periods keep channels firing; wide ones cover the high bits
        if (pick < 70)
            period = $urandom_range(1, 40);
        else if (pick < 90)
            period = $urandom;
        else
            period = '0;
        if (req == atb_pkg::REQ_TICK) begin
            if ($urandom_range(0, 99) < 5)
                cur_time = $urandom;
            else
                cur_time = cur_time + $urandom_range(0, 25);
        end
        now = ($urandom_range(0, 99) < 8) ? $urandom : cur_time;
        send_word(req, ch, period, 1'($urandom_range(0, 1)), $urandom_range(0, 99) < 85, now);
    endtask

    // receiver: random back-pressure, or a long hold-off when asked
    initial begin
        int holdoff_seen;
        holdoff_seen = 0;
        m_ready      = 1'b0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (holdoff_asked != holdoff_seen) begin
                holdoff_seen = holdoff_asked;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_report(m_status_ok, m_fired, m_fired_channel, m_last_result);
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[multi_channel_alarm_timer_bank] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        sb              = new();
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_req_type      = '0;
        s_channel       = '0;
        s_period_value  = '0;
        s_periodic_mode = 1'b0;
        s_has_handler   = 1'b0;
        s_now_time      = '0;
        send_idle_pct   = 13;
        recv_idle_pct   = 53;
        holdoff_asked   = 0;
        quiet_cycles    = 0;
        cur_time        = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // undefined request codes are refused and change nothing
        send_word(alarm_check_pkg::REQ_RSVD_6, 3'd2, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_word(alarm_check_pkg::REQ_RSVD_7, 3'd7, 32'h0, 1'b0, 1'b0, 32'h0);
        // nothing armed after reset: a quiet tick
        send_word(atb_pkg::REQ_TICK, 3'd0, 32'h0, 1'b0, 1'b0, 32'hFFFF_FFFF);

        // every channel gets a handler; odd ones periodic, the last with the widest period
        for (int c = 0; c < alarm_check_pkg::NUM_CH; c++)
            send_word(atb_pkg::REQ_SETUP, 3'(c),
                      (c == alarm_check_pkg::NUM_CH - 1) ? 32'hFFFF_FFFF : 32'(c + 1),
                      1'(c % 2), 1'b1, 32'h0);
        // start just below the wrap point so the next tick compares due times across it
        for (int c = 0; c < alarm_check_pkg::NUM_CH; c++)
            send_word(atb_pkg::REQ_START, 3'(c), 32'h0, 1'b0, 1'b0, 32'hFFFF_FFF0);
        // past the wrap every channel is due: a full burst of fired words
        send_word(atb_pkg::REQ_TICK, 3'd5, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0100);

        // zero period is refused, a new period reloads the due time of an armed channel
        send_word(atb_pkg::REQ_SETPER, 3'd1, 32'h0, 1'b0, 1'b0, 32'h0000_0100);
        send_word(atb_pkg::REQ_SETPER, 3'd1, 32'h8000_0000, 1'b0, 1'b0, 32'h0000_0100);
        send_word(atb_pkg::REQ_STOP, 3'd3, 32'h0, 1'b0, 1'b0, 32'h0);
        // no handler: restart refused
        send_word(atb_pkg::REQ_SETUP, 3'd5, 32'd9, 1'b1, 1'b0, 32'h0);
        send_word(atb_pkg::REQ_RESTART, 3'd5, 32'h0, 1'b0, 1'b0, 32'h0000_0200);
        send_word(atb_pkg::REQ_RESTART, 3'd0, 32'h0, 1'b0, 1'b0, 32'h0000_0200);
        // channel 1 sits half a wrap away and must not fire
        send_word(atb_pkg::REQ_TICK, 3'd0, 32'h0, 1'b0, 1'b0, 32'h0000_0201);
        // zero period through setup is taken, but start then refuses
        send_word(atb_pkg::REQ_SETUP, 3'd1, 32'h0, 1'b1, 1'b1, 32'h0);
        send_word(atb_pkg::REQ_START, 3'd1, 32'h0, 1'b0, 1'b0, 32'h0);
        cur_time = 32'h0000_0201;

        // three passes: slow receiver, slow sender, then full rate
        for (int pass = 0; pass < 3; pass++) begin
            if (pass == 1) begin
                send_idle_pct = 53;
                recv_idle_pct <= 13;
            end else if (pass == 2) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            for (int k = 0; k < ITEMS_PER_PASS; k++) begin
                // long hold-off while the sender keeps pushing, to back up the input
                if (pass == 0 && k == 20)
                    holdoff_asked <= holdoff_asked + 1;
                // sender pause until the bank has emptied
                if (k == 40)
                    wait_for_drain();
                rand_request();
            end
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SCAN_CYCLES + 10) @(posedge aclk);

        if (sb.errors == 0)
            $display("[multi_channel_alarm_timer_bank] OK");
        else
            $display("[multi_channel_alarm_timer_bank] ERROR");
        $finish;
    end

endmodule
